[rtl/nfala_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfala_pkg
// Shared types, codes and the control store of the lambda-NFA acceptor.
// ----------------------------------------------------------------------------
package nfala_pkg;

  localparam int STATE_BITS = 4;
  localparam int SYM_BITS   = 8;
  localparam int INIT_CNT_W = 5;
  localparam int ACC_MASK_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int UPC_W      = 4;
  // states reachable through the 4-bit state fields
  localparam int LOW_STATES = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_SYMBOL = 2'd2,
    CMD_EMPTY  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_COUNT = 1'b0,
    CFG_ACCEPT_MASK   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SET_HOLD = 2'd0,
    SET_INIT = 2'd1,
    SET_NXT  = 2'd2
  } set_op_e;

  typedef enum logic [1:0] {
    SW_NONE   = 2'd0,
    SW_LAMBDA = 2'd1,
    SW_SYMBOL = 2'd2
  } sweep_e;

  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_DISPATCH = 3'd1,
    J_SWEEP    = 3'd2,
    J_CLOS     = 3'd3,
    J_LAST     = 3'd4,
    J_EMIT     = 3'd5,
    J_GOTO     = 3'd6
  } jump_e;

  // micro-addresses
  localparam logic [UPC_W-1:0] UA_IDLE    = 4'd0;
  localparam logic [UPC_W-1:0] UA_SI_INIT = 4'd1;
  localparam logic [UPC_W-1:0] UA_SI_CLR  = 4'd2;
  localparam logic [UPC_W-1:0] UA_SI_CL   = 4'd3;
  localparam logic [UPC_W-1:0] UA_ST_CLR  = 4'd4;
  localparam logic [UPC_W-1:0] UA_ST_SW   = 4'd5;
  localparam logic [UPC_W-1:0] UA_ST_COPY = 4'd6;
  localparam logic [UPC_W-1:0] UA_SC_CLR  = 4'd7;
  localparam logic [UPC_W-1:0] UA_SC_CL   = 4'd8;
  localparam logic [UPC_W-1:0] UA_ST_END  = 4'd9;
  localparam logic [UPC_W-1:0] UA_EM_INIT = 4'd10;
  localparam logic [UPC_W-1:0] UA_EM_CLR  = 4'd11;
  localparam logic [UPC_W-1:0] UA_EM_CL   = 4'd12;
  localparam logic [UPC_W-1:0] UA_EMIT    = 4'd13;

  typedef struct packed {
    logic                       lam;
    logic [SYM_BITS-1:0]        sym;
    logic [STATE_BITS-1:0]      to;
    logic [STATE_BITS-1:0]      from;
  } entry_t;

  typedef struct packed {
    logic             in_rdy;
    set_op_e          set_op;
    logic             sw_init;
    sweep_e           sw_mode;
    logic             inside_set;
    logic             inside_clr;
    logic             emit;
    jump_e            jmp;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic sweep_done;
    logic changed;
    logic last;
    logic out_free;
  } dp_stat_t;

  function automatic uword_t ucode(logic [UPC_W-1:0] a);
    uword_t w;
    w = '0;
    unique case (a)
      UA_IDLE: begin
        w.in_rdy = 1'b1;
        w.jmp    = J_DISPATCH;
      end
      UA_SI_INIT: begin
        w.set_op     = SET_INIT;
        w.inside_set = 1'b1;
        w.jmp        = J_NEXT;
      end
      UA_SI_CLR, UA_ST_CLR, UA_SC_CLR, UA_EM_CLR: begin
        w.sw_init = 1'b1;
        w.jmp     = J_NEXT;
      end
      UA_SI_CL: begin
        w.sw_mode = SW_LAMBDA;
        w.jmp     = J_CLOS;
        w.target  = UA_SI_CLR;
      end
      UA_ST_SW: begin
        w.sw_mode = SW_SYMBOL;
        w.jmp     = J_SWEEP;
      end
      UA_ST_COPY: begin
        w.set_op = SET_NXT;
        w.jmp    = J_NEXT;
      end
      UA_SC_CL: begin
        w.sw_mode = SW_LAMBDA;
        w.jmp     = J_CLOS;
        w.target  = UA_SC_CLR;
      end
      UA_ST_END: begin
        w.jmp    = J_LAST;
        w.target = UA_EMIT;
      end
      UA_EM_INIT: begin
        w.set_op = SET_INIT;
        w.jmp    = J_NEXT;
      end
      UA_EM_CL: begin
        w.sw_mode = SW_LAMBDA;
        w.jmp     = J_CLOS;
        w.target  = UA_EM_CLR;
      end
      UA_EMIT: begin
        w.emit       = 1'b1;
        w.inside_clr = 1'b1;
        w.jmp        = J_EMIT;
      end
      default: begin
        w.jmp    = J_GOTO;
        w.target = UA_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/nfala_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfala_store
// Transition memory with fill count and sticky overflow flag.
// ----------------------------------------------------------------------------
module nfala_store #(
  parameter int MAX_TRANSITIONS = 64,
  parameter int CW              = 7,
  parameter int AW              = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               wr_i,
  input  nfala_pkg::entry_t  wr_entry_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output nfala_pkg::entry_t  rd_entry_o,
  output logic [CW-1:0]      count_o,
  output logic               ovf_o
);
  import nfala_pkg::*;

  entry_t        mem [MAX_TRANSITIONS];
  entry_t        rd_q;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          full;

  assign full = (count_q == CW'(MAX_TRANSITIONS));

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (clr_i) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (wr_i) begin
      if (full) ovf_d = 1'b1;
      else      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && !full) mem[count_q[AW-1:0]] <= wr_entry_i;
    if (rd_en_i) rd_q <= mem[rd_addr_i];
  end

  assign rd_entry_o = rd_q;
  assign count_o    = count_q;
  assign ovf_o      = ovf_q;

endmodule

[rtl/nfala_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfala_seq
// Micro-program counter, control store lookup and conditional jumps.
// ----------------------------------------------------------------------------
module nfala_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  nfala_pkg::cmd_e     in_cmd_i,
  input  nfala_pkg::dp_stat_t stat_i,
  output nfala_pkg::uword_t   uw_o
);
  import nfala_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d, upc_inc, dispatch;
  logic             inside_q, inside_d;
  logic             accept;
  uword_t           uw;

  assign uw      = ucode(upc_q);
  assign accept  = in_valid_i && uw.in_rdy;
  assign upc_inc = upc_q + UPC_W'(1);

  always_comb begin
    unique case (in_cmd_i)
      CMD_CLEAR, CMD_ADD: dispatch = UA_IDLE;
      CMD_SYMBOL:         dispatch = inside_q ? UA_ST_CLR : UA_SI_INIT;
      CMD_EMPTY:          dispatch = UA_EM_INIT;
      default:            dispatch = UA_IDLE;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    unique case (uw.jmp)
      J_NEXT:     upc_d = upc_inc;
      J_DISPATCH: if (accept) upc_d = dispatch;
      J_SWEEP:    if (stat_i.sweep_done) upc_d = upc_inc;
      J_CLOS:     if (stat_i.sweep_done) upc_d = stat_i.changed ? uw.target : upc_inc;
      J_LAST:     upc_d = stat_i.last ? uw.target : UA_IDLE;
      J_EMIT:     if (stat_i.out_free) upc_d = UA_IDLE;
      J_GOTO:     upc_d = uw.target;
      default:    upc_d = UA_IDLE;
    endcase
  end

  always_comb begin
    inside_d = inside_q;
    priority if (accept && in_cmd_i == CMD_CLEAR) inside_d = 1'b0;
    else if (uw.inside_clr)                       inside_d = 1'b0;
    else if (uw.inside_set)                       inside_d = 1'b1;
    else                                          inside_d = inside_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q    <= UA_IDLE;
      inside_q <= 1'b0;
    end else begin
      upc_q    <= upc_d;
      inside_q <= inside_d;
    end
  end

  assign uw_o = uw;

endmodule

[rtl/nfala_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfala_dp
// Active-set datapath: sweep address, set and next-set registers, config
// registers and the result register.
// ----------------------------------------------------------------------------
module nfala_dp #(
  parameter int NUM_STATES = 16,
  parameter int CW         = 7,
  parameter int AW         = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  nfala_pkg::cfg_idx_e                 cfg_idx_i,
  input  logic [nfala_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                accept_i,
  input  logic [nfala_pkg::SYM_BITS-1:0]      in_sym_i,
  input  logic                                in_last_i,
  input  nfala_pkg::uword_t                   uw_i,
  input  logic [CW-1:0]                       count_i,
  input  logic                                ovf_i,
  input  nfala_pkg::entry_t                   rd_entry_i,
  output logic                                rd_en_o,
  output logic [AW-1:0]                       rd_addr_o,
  output nfala_pkg::dp_stat_t                 stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_acc_o,
  output logic                                out_ovf_o
);
  import nfala_pkg::*;

  logic [NUM_STATES-1:0] set_q, set_d, nxt_q, nxt_d, init_set, tbit;
  logic [LOW_STATES-1:0] set16;
  logic [INIT_CNT_W-1:0] init_cnt_q;
  logic [ACC_MASK_W-1:0] acc_mask_q;
  logic [CW-1:0]         addr_q, addr_d;
  logic                  rdv_q, chg_q, chg_d;
  logic [SYM_BITS-1:0]   sym_q;
  logic                  last_q;
  logic                  out_vld_q, out_vld_d, out_acc_q, out_ovf_q;
  logic                  issue, src_hit, lam_fire, sym_fire, out_free, emit_fire;

  // low states seen through the 4-bit state fields
  for (genvar j = 0; j < LOW_STATES; j++) begin : g_low
    if (j < NUM_STATES) begin : g_in
      assign set16[j] = set_q[j];
    end else begin : g_out
      assign set16[j] = 1'b0;
    end
  end

  for (genvar j = 0; j < NUM_STATES; j++) begin : g_tgt
    if (j < LOW_STATES) begin : g_in
      assign tbit[j] = (rd_entry_i.to == STATE_BITS'(j));
    end else begin : g_out
      assign tbit[j] = 1'b0;
    end
  end

  // initial states 0 .. count-1, saturating at the state count
  always_comb begin
    for (int j = 0; j < NUM_STATES; j++) init_set[j] = (int'(init_cnt_q) > j);
  end

  assign issue    = (uw_i.sw_mode != SW_NONE) && (addr_q < count_i);
  assign src_hit  = set16[rd_entry_i.from];
  assign lam_fire = rdv_q && (uw_i.sw_mode == SW_LAMBDA) && rd_entry_i.lam && src_hit;
  assign sym_fire = rdv_q && (uw_i.sw_mode == SW_SYMBOL) && !rd_entry_i.lam &&
                    (rd_entry_i.sym == sym_q) && src_hit;
  assign out_free  = !out_vld_q || out_ready_i;
  assign emit_fire = uw_i.emit && out_free;

  always_comb begin
    set_d = set_q;
    unique case (uw_i.set_op)
      SET_INIT: set_d = init_set;
      SET_NXT:  set_d = nxt_q;
      SET_HOLD: if (lam_fire) set_d = set_q | tbit;
      default:  set_d = set_q;
    endcase
  end

  always_comb begin
    if (uw_i.sw_init) begin
      nxt_d  = '0;
      chg_d  = 1'b0;
      addr_d = '0;
    end else begin
      nxt_d  = sym_fire ? (nxt_q | tbit) : nxt_q;
      chg_d  = chg_q || (lam_fire && |(tbit & ~set_q));
      addr_d = issue ? addr_q + CW'(1) : addr_q;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    priority if (emit_fire) out_vld_d = 1'b1;
    else if (out_ready_i)   out_vld_d = 1'b0;
    else                    out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q      <= '0;
      nxt_q      <= '0;
      chg_q      <= 1'b0;
      addr_q     <= '0;
      rdv_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      init_cnt_q <= INIT_CNT_W'(1);
      acc_mask_q <= '0;
    end else begin
      set_q     <= set_d;
      nxt_q     <= nxt_d;
      chg_q     <= chg_d;
      addr_q    <= addr_d;
      rdv_q     <= issue;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_INITIAL_COUNT: init_cnt_q <= cfg_data_i[INIT_CNT_W-1:0];
          CFG_ACCEPT_MASK:   acc_mask_q <= cfg_data_i[ACC_MASK_W-1:0];
          default:           ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sym_q  <= in_sym_i;
      last_q <= in_last_i;
    end
    if (emit_fire) begin
      out_acc_q <= |(set16 & acc_mask_q);
      out_ovf_q <= ovf_i;
    end
  end

  assign rd_en_o   = issue;
  assign rd_addr_o = addr_q[AW-1:0];

  assign stat_o.sweep_done = !issue && !rdv_q;
  assign stat_o.changed    = chg_q;
  assign stat_o.last       = last_q;
  assign stat_o.out_free   = out_free;

  assign out_valid_o = out_vld_q;
  assign out_acc_o   = out_acc_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

[rtl/nfa_lambda_acceptor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_lambda_acceptor
// Lambda-NFA string acceptor run by a microcoded sequencer over a
// transition memory.
// ----------------------------------------------------------------------------
// clear and add beats keep the sequencer idle, so the input stays ready for the next beat.
// a sweep reads every stored transition; a closure runs 1 to NUM_STATES sweeps until settled.
// symbol beat: clear, symbol sweep, copy, closure; a string's first symbol first loads and closes the initial set,
// and the last adds an emit step (held while the result is stalled); empty query: initial set, closure, emit.
// reset clears the count, flags, active set and config to their defaults.
module nfa_lambda_acceptor #(
  parameter int NUM_STATES      = 16,
  parameter int MAX_TRANSITIONS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] source state, [7:4] target state, [15:8] symbol
  input  logic [15:0] s_axis_tdata,
  // [1:0] command, [2] is_lambda
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [1] table_overflowed, [7:2] zero
  output logic [7:0]  m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [nfala_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [nfala_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import nfala_pkg::*;

  localparam int CW = $clog2(MAX_TRANSITIONS + 1);
  localparam int AW = $clog2(MAX_TRANSITIONS);

  uword_t        uw;
  dp_stat_t      stat;
  cmd_e          cmd;
  entry_t        wr_entry, rd_entry;
  logic          accept, rd_en, ovf, out_acc, out_ovf;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count;

  assign cmd    = cmd_e'(s_axis_tuser[1:0]);
  assign accept = s_axis_tvalid && uw.in_rdy;

  assign wr_entry.from = s_axis_tdata[3:0];
  assign wr_entry.to   = s_axis_tdata[7:4];
  assign wr_entry.sym  = s_axis_tdata[15:8];
  assign wr_entry.lam  = s_axis_tuser[2];

  nfala_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (cmd),
    .stat_i     (stat),
    .uw_o       (uw)
  );

  nfala_store #(
    .MAX_TRANSITIONS (MAX_TRANSITIONS),
    .CW              (CW),
    .AW              (AW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (accept && cmd == CMD_CLEAR),
    .wr_i       (accept && cmd == CMD_ADD),
    .wr_entry_i (wr_entry),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .count_o    (count),
    .ovf_o      (ovf)
  );

  nfala_dp #(
    .NUM_STATES (NUM_STATES),
    .CW         (CW),
    .AW         (AW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_sym_i    (s_axis_tdata[15:8]),
    .in_last_i   (s_axis_tlast),
    .uw_i        (uw),
    .count_i     (count),
    .ovf_i       (ovf),
    .rd_entry_i  (rd_entry),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_acc_o   (out_acc),
    .out_ovf_o   (out_ovf)
  );

  assign s_axis_tready = uw.in_rdy;
  assign m_axis_tdata  = {6'b0, out_ovf, out_acc};

endmodule

[rtl/nfala_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfala_checker
// Port-level checks on the lambda-NFA acceptor, bound to the top level.
// ----------------------------------------------------------------------------
module nfala_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);
  import nfala_pkg::*;

  // out of reset the sequencer sits ready for a beat
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready)
    else $error("input not ready after reset");

  // clear and add beats leave the input ready for the next beat
  a_store_beat_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser[1:0] == CMD_CLEAR || s_axis_tuser[1:0] == CMD_ADD))
    |=> s_axis_tready)
    else $error("input stalled after a store beat");

  // a verdict is only produced while the sequencer is busy
  a_verdict_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("verdict appeared from idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

endmodule

bind nfa_lambda_acceptor nfala_checker u_nfala_checker (.*);
